@@ sv/wta_pkg.sv @@
// ----------------------------------------------------------------------------
// wta_pkg: shared constants for the windowed table average core
// Widths of the fields, configuration register indexes and defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package wta_pkg;
  localparam int TABLE_DEPTH_DEF = 128;
  localparam int POS_W = 32;
  localparam int VAL_W = 32;
  localparam int HW_W = 24;
  localparam int PTS_W = 8;
  localparam int IDX_W = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;
  localparam int PROD_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_POINTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF = 2'd1;

  localparam logic [PTS_W-1:0] POINTS_RESET = 8'd2;
  localparam logic [HW_W-1:0] HALF_RESET = 24'd32768;

  localparam logic [0:0] KIND_LOAD = 1'b0;
  localparam logic [0:0] KIND_QUERY = 1'b1;
endpackage

@@ sv/wta_table.sv @@
// ----------------------------------------------------------------------------
// wta_table: sample table memory
// One write port and one registered read port holding position and value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module wta_table import wta_pkg::*; #(
  parameter int DEPTH = TABLE_DEPTH_DEF,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic [POS_W-1:0]        wpos,
  input  logic signed [VAL_W-1:0] wval,
  input  logic [AW-1:0]           raddr,
  output logic [POS_W-1:0]        rpos,
  output logic signed [VAL_W-1:0] rval
);
  logic [POS_W+VAL_W-1:0] mem [DEPTH];
  logic [POS_W+VAL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wpos, wval};
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rpos = rdata_r[POS_W+VAL_W-1:VAL_W];
  assign rval = rdata_r[VAL_W-1:0];
endmodule

@@ sv/wta_div.sv @@
// ----------------------------------------------------------------------------
// wta_div: shared unsigned divider
// Restoring division of a 64-bit dividend by a 32-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module wta_div import wta_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [PROD_W-1:0] dividend,
  input  logic [POS_W-1:0]  divisor,
  output logic [PROD_W-1:0] quotient,
  output logic              done
);
  localparam int CW = $clog2(PROD_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [PROD_W-1:0] quo_r, quo_nxt;
  logic [POS_W:0]    rem_r, rem_nxt;
  logic [POS_W-1:0]  dsr_r, dsr_nxt;
  logic [POS_W:0]    shifted;
  logic              fits;

  always_comb begin
    shifted = {rem_r[POS_W-1:0], quo_r[PROD_W-1]};
    fits = shifted >= {1'b0, dsr_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt = cnt_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dsr_nxt = dsr_r;
    if (go) begin
      busy_nxt = 1'b1;
      cnt_nxt = '0;
      quo_nxt = dividend;
      rem_nxt = '0;
      dsr_nxt = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? shifted - {1'b0, dsr_r} : shifted;
      quo_nxt = {quo_r[PROD_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(PROD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign quotient = quo_r;
  assign done = done_r;
endmodule

@@ sv/windowed_table_average_core.sv @@
// ----------------------------------------------------------------------------
// windowed_table_average_core: box-filtered piecewise-linear table lookup
// Loads table entries and answers windowed averages over the interpolated curve.
// ----------------------------------------------------------------------------
//
//   channel   ports                                   handshake
//   input     in_kind, in_entry_index, in_position,   start high, busy low
//             in_sample_value
//   result    out_average, out_empty_window           out_valid strobe, 1 cycle
//   config    cfg_we, cfg_index, cfg_wdata            cfg_we high
//
// A load beat is written to the table in the cycle it is accepted; busy stays low.
// A query reads the span ends, then reads each segment's ends in turn. A segment that
// misses the window is skipped; one that overlaps it is interpolated at both clipped
// ends and its trapezoid accumulated. The final division follows, and the result beat
// comes in the cycle after it is done. The shared bit-serial divider (one quotient bit
// per cycle, run twice per overlapped segment) serves both steps.
// Reset is synchronous; the receiver cannot stall the result beat.
//
`timescale 1ns / 1ps
module windowed_table_average_core import wta_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_kind,
  input  logic [IDX_W-1:0]        in_entry_index,
  input  logic [POS_W-1:0]        in_position,
  input  logic signed [VAL_W-1:0] in_sample_value,
  output logic                    out_valid,
  output logic signed [VAL_W-1:0] out_average,
  output logic                    out_empty_window,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int NW = $clog2(TABLE_DEPTH + 1) + 1;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_RDFIRST = 4'd1;
  localparam logic [3:0] S_RDLAST  = 4'd2;
  localparam logic [3:0] S_SEGA    = 4'd3;
  localparam logic [3:0] S_SEGB    = 4'd4;
  localparam logic [3:0] S_LMUL    = 4'd5;
  localparam logic [3:0] S_LDIVGO  = 4'd6;
  localparam logic [3:0] S_LDIV    = 4'd7;
  localparam logic [3:0] S_TMUL    = 4'd8;
  localparam logic [3:0] S_TACC    = 4'd9;
  localparam logic [3:0] S_NEXT    = 4'd10;
  localparam logic [3:0] S_FDIVGO  = 4'd11;
  localparam logic [3:0] S_FDIV    = 4'd12;

  logic [3:0] state_r, state_nxt;

  // Configuration registers.
  logic [PTS_W-1:0] points_r;
  logic [HW_W-1:0]  hw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_r <= POINTS_RESET;
      hw_r <= HALF_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_POINTS) begin
        points_r <= cfg_wdata[PTS_W-1:0];
      end else if (cfg_index == REG_HALF) begin
        hw_r <= cfg_wdata[HW_W-1:0];
      end
    end
  end

  // Query working registers.
  logic [POS_W-1:0]        qpos_r, qpos_nxt;
  logic [NW-1:0]           n_r, n_nxt;
  logic [POS_W-1:0]        p0_r, p0_nxt;
  logic [POS_W-1:0]        wstart_r, wstart_nxt;
  logic [POS_W-1:0]        wend_r, wend_nxt;
  logic [AW-1:0]           i_r, i_nxt;
  logic [POS_W-1:0]        a_r, a_nxt;
  logic [POS_W-1:0]        b_r, b_nxt;
  logic signed [VAL_W-1:0] fa_r, fa_nxt;
  logic signed [VAL_W:0]   d_r, d_nxt;
  logic [POS_W-1:0]        ca_r, ca_nxt;
  logic [POS_W-1:0]        cb_r, cb_nxt;
  logic signed [VAL_W-1:0] fx0_r, fx0_nxt;
  logic signed [VAL_W-1:0] fx1_r, fx1_nxt;
  logic                    sel_r, sel_nxt;
  logic [PROD_W-1:0]       prod_r, prod_nxt;
  logic signed [PROD_W-1:0] acc_r, acc_nxt;
  logic                    ovalid_r, ovalid_nxt;
  logic signed [VAL_W-1:0] oavg_r, oavg_nxt;
  logic                    oempty_r, oempty_nxt;

  // Table and divider connections.
  logic                    tbl_we;
  logic [AW-1:0]           tbl_waddr;
  logic [AW-1:0]           tbl_raddr;
  logic [POS_W-1:0]        tbl_rpos;
  logic signed [VAL_W-1:0] tbl_rval;
  logic                    div_go;
  logic [PROD_W-1:0]       div_dividend;
  logic [POS_W-1:0]        div_divisor;
  logic [PROD_W-1:0]       div_quo;
  logic                    div_done;

  logic [15:0] idx_wide;
  logic [15:0] pts_wide;
  logic [NW-1:0] n_clamped;
  logic [NW-1:0] nm1;

  // Shared multiplier operands.
  logic [VAL_W:0]          mul_a;
  logic [POS_W-1:0]        mul_b;
  logic [PROD_W:0]         mul_p;

  logic [VAL_W:0]          dmag;
  logic signed [VAL_W:0]   ssum;
  logic [VAL_W:0]          smag;
  logic signed [POS_W+1:0] lo;
  logic [POS_W:0]          hi;
  logic [POS_W-1:0]        st_c, en_c, ca_c, cb_c;
  logic signed [VAL_W+1:0] fx_c;
  logic [VAL_W:0]          q_lerp;
  logic signed [PROD_W:0]  tv, tsum;
  logic [PROD_W-1:0]       accmag;

  assign idx_wide = {{(16-IDX_W){1'b0}}, in_entry_index};
  assign pts_wide = {{(16-PTS_W){1'b0}}, points_r};
  assign tbl_we = (state_r == S_IDLE) && start && (in_kind == KIND_LOAD) &&
                  (idx_wide < 16'(TABLE_DEPTH));
  assign tbl_waddr = idx_wide[AW-1:0];

  always_comb begin
    if (pts_wide < 16'd2) begin
      n_clamped = NW'(2);
    end else if (pts_wide > 16'(TABLE_DEPTH)) begin
      n_clamped = NW'(TABLE_DEPTH);
    end else begin
      n_clamped = pts_wide[NW-1:0];
    end
  end
  assign nm1 = n_r - 1'b1;

  always_comb begin
    case (state_r)
      S_RDFIRST: tbl_raddr = nm1[AW-1:0];
      S_SEGA:    tbl_raddr = i_r + 1'b1;
      S_NEXT:    tbl_raddr = i_r + 1'b1;
      default:   tbl_raddr = '0;
    endcase
  end

  assign dmag = d_r[VAL_W] ? (VAL_W + 1)'(0) - d_r : d_r;
  assign ssum = {fx0_r[VAL_W-1], fx0_r} + {fx1_r[VAL_W-1], fx1_r};
  assign smag = ssum[VAL_W] ? (VAL_W + 1)'(0) - ssum : ssum;

  always_comb begin
    if (state_r == S_TMUL) begin
      mul_a = smag;
      mul_b = cb_r - ca_r;
    end else begin
      mul_a = dmag;
      mul_b = sel_r ? cb_r - a_r : ca_r - a_r;
    end
  end
  assign mul_p = mul_a * mul_b;

  // Window ends clipped to the table span.
  assign lo = {2'b00, qpos_r} - {{(POS_W + 2 - HW_W){1'b0}}, hw_r};
  assign hi = {1'b0, qpos_r} + {{(POS_W + 1 - HW_W){1'b0}}, hw_r};
  assign st_c = (lo > $signed({2'b00, p0_r})) ? lo[POS_W-1:0] : p0_r;
  assign en_c = (hi < {1'b0, tbl_rpos}) ? hi[POS_W-1:0] : tbl_rpos;

  // Segment clipped to the window.
  assign ca_c = (a_r > wstart_r) ? a_r : wstart_r;
  assign cb_c = (tbl_rpos < wend_r) ? tbl_rpos : wend_r;

  assign q_lerp = div_quo[VAL_W:0];
  assign fx_c = d_r[VAL_W] ? {{2{fa_r[VAL_W-1]}}, fa_r} - {1'b0, q_lerp}
                           : {{2{fa_r[VAL_W-1]}}, fa_r} + {1'b0, q_lerp};

  // Half the trapezoid product carries the sign of the value sum.
  assign tv = ssum[VAL_W] ? (PROD_W + 1)'(0) - {2'b00, prod_r[PROD_W-1:1]}
                          : {2'b00, prod_r[PROD_W-1:1]};
  assign tsum = {acc_r[PROD_W-1], acc_r} + tv;
  assign accmag = acc_r[PROD_W-1] ? PROD_W'(0) - acc_r : acc_r;

  assign div_go = (state_r == S_LDIVGO) || (state_r == S_FDIVGO);
  assign div_dividend = (state_r == S_FDIVGO) ? accmag : prod_r;
  assign div_divisor = (state_r == S_FDIVGO) ? {{(POS_W - HW_W - 1){1'b0}}, hw_r, 1'b0}
                                             : b_r - a_r;

  always_comb begin
    state_nxt = state_r;
    qpos_nxt = qpos_r;
    n_nxt = n_r;
    p0_nxt = p0_r;
    wstart_nxt = wstart_r;
    wend_nxt = wend_r;
    i_nxt = i_r;
    a_nxt = a_r;
    b_nxt = b_r;
    fa_nxt = fa_r;
    d_nxt = d_r;
    ca_nxt = ca_r;
    cb_nxt = cb_r;
    fx0_nxt = fx0_r;
    fx1_nxt = fx1_r;
    sel_nxt = sel_r;
    prod_nxt = prod_r;
    acc_nxt = acc_r;
    ovalid_nxt = 1'b0;
    oavg_nxt = oavg_r;
    oempty_nxt = oempty_r;
    case (state_r)
      S_IDLE: begin
        if (start && (in_kind == KIND_QUERY)) begin
          qpos_nxt = in_position;
          n_nxt = n_clamped;
          state_nxt = S_RDFIRST;
        end
      end
      S_RDFIRST: begin
        p0_nxt = tbl_rpos;
        state_nxt = S_RDLAST;
      end
      S_RDLAST: begin
        wstart_nxt = st_c;
        wend_nxt = en_c;
        if ((en_c <= st_c) || (hw_r == '0)) begin
          ovalid_nxt = 1'b1;
          oavg_nxt = '0;
          oempty_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          i_nxt = '0;
          acc_nxt = '0;
          state_nxt = S_SEGA;
        end
      end
      S_SEGA: begin
        a_nxt = tbl_rpos;
        fa_nxt = tbl_rval;
        state_nxt = S_SEGB;
      end
      S_SEGB: begin
        b_nxt = tbl_rpos;
        d_nxt = {tbl_rval[VAL_W-1], tbl_rval} - {fa_r[VAL_W-1], fa_r};
        ca_nxt = ca_c;
        cb_nxt = cb_c;
        sel_nxt = 1'b0;
        state_nxt = (ca_c >= cb_c) ? S_NEXT : S_LMUL;
      end
      S_LMUL: begin
        prod_nxt = mul_p[PROD_W-1:0];
        state_nxt = S_LDIVGO;
      end
      S_LDIVGO: begin
        state_nxt = S_LDIV;
      end
      S_LDIV: begin
        if (div_done) begin
          if (sel_r) begin
            fx1_nxt = fx_c[VAL_W-1:0];
            state_nxt = S_TMUL;
          end else begin
            fx0_nxt = fx_c[VAL_W-1:0];
            sel_nxt = 1'b1;
            state_nxt = S_LMUL;
          end
        end
      end
      S_TMUL: begin
        prod_nxt = mul_p[PROD_W-1:0];
        state_nxt = S_TACC;
      end
      S_TACC: begin
        if (tsum[PROD_W] != tsum[PROD_W-1]) begin
          acc_nxt = tsum[PROD_W] ? {1'b1, {(PROD_W-1){1'b0}}} : {1'b0, {(PROD_W-1){1'b1}}};
        end else begin
          acc_nxt = tsum[PROD_W-1:0];
        end
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        if (({{(NW-AW){1'b0}}, i_r} + NW'(2)) >= n_r) begin
          state_nxt = S_FDIVGO;
        end else begin
          i_nxt = i_r + 1'b1;
          state_nxt = S_SEGA;
        end
      end
      S_FDIVGO: begin
        state_nxt = S_FDIV;
      end
      S_FDIV: begin
        if (div_done) begin
          if (acc_r[PROD_W-1]) begin
            if (div_quo > PROD_W'(64'h8000_0000)) begin
              oavg_nxt = {1'b1, {(VAL_W-1){1'b0}}};
            end else begin
              oavg_nxt = VAL_W'(0) - div_quo[VAL_W-1:0];
            end
          end else begin
            if (div_quo > PROD_W'(64'h7FFF_FFFF)) begin
              oavg_nxt = {1'b0, {(VAL_W-1){1'b1}}};
            end else begin
              oavg_nxt = div_quo[VAL_W-1:0];
            end
          end
          oempty_nxt = 1'b0;
          ovalid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
    qpos_r <= qpos_nxt;
    n_r <= n_nxt;
    p0_r <= p0_nxt;
    wstart_r <= wstart_nxt;
    wend_r <= wend_nxt;
    i_r <= i_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    fa_r <= fa_nxt;
    d_r <= d_nxt;
    ca_r <= ca_nxt;
    cb_r <= cb_nxt;
    fx0_r <= fx0_nxt;
    fx1_r <= fx1_nxt;
    sel_r <= sel_nxt;
    prod_r <= prod_nxt;
    acc_r <= acc_nxt;
    oavg_r <= oavg_nxt;
    oempty_r <= oempty_nxt;
  end

  wta_table #(
    .DEPTH(TABLE_DEPTH),
    .AW(AW)
  ) u_table (
    .clk(clk),
    .we(tbl_we),
    .waddr(tbl_waddr),
    .wpos(in_position),
    .wval(in_sample_value),
    .raddr(tbl_raddr),
    .rpos(tbl_rpos),
    .rval(tbl_rval)
  );

  wta_div u_div (
    .clk(clk),
    .rst_n(rst_n),
    .go(div_go),
    .dividend(div_dividend),
    .divisor(div_divisor),
    .quotient(div_quo),
    .done(div_done)
  );

  assign busy = (state_r != S_IDLE);
  assign out_valid = ovalid_r;
  assign out_average = oavg_r;
  assign out_empty_window = oempty_r;
endmodule

@@ tb/sv/wta_checker.sv @@
// ----------------------------------------------------------------------------
// wta_checker: result predictor and scoreboard for the windowed table average
// Watches the load, query, result and register ports, predicts each query's
// average from its own copy of the table, and compares results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module wta_checker import wta_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    busy,
  input  logic                    in_kind,
  input  logic [IDX_W-1:0]        in_entry_index,
  input  logic [POS_W-1:0]        in_position,
  input  logic signed [VAL_W-1:0] in_sample_value,
  input  logic                    out_valid,
  input  logic signed [VAL_W-1:0] out_average,
  input  logic                    out_empty_window,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  output int                      fail_count,
  output int                      pending_averages
);

  typedef struct packed {
    logic signed [VAL_W-1:0] average;
    logic                    empty_window;
  } average_t;

  localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint SUM_MIN = -64'sh7FFF_FFFF_FFFF_FFFF - 64'sd1;

  logic [POS_W-1:0]        pos_tab [TABLE_DEPTH_DEF];
  logic signed [VAL_W-1:0] val_tab [TABLE_DEPTH_DEF];
  logic [PTS_W-1:0]        points_reg;
  logic [HW_W-1:0]         half_reg;
  average_t                expected_averages[$];
  int                      query_no;

  assign pending_averages = expected_averages.size();

  task automatic report(input string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  // Value of the segment from fa to fb at fraction num/den, step truncated to zero.
  function automatic longint interp(input longint fa, input longint fb,
                                    input longint unsigned num,
                                    input longint unsigned den);
    longint d;
    longint unsigned mag;
    longint unsigned q;
    d = fb - fa;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    q = (mag * num) / den;
    return (d < 0) ? fa - longint'(q) : fa + longint'(q);
  endfunction

  function automatic average_t predict_average(input logic [POS_W-1:0] center);
    average_t r;
    int       n;
    longint   lo, hi, span_lo, span_hi, acc, a, b, ca, cb, fa, fb, s, v, avg;
    longint unsigned mag, half;
    n = int'(points_reg);
    if (n < 2) n = 2;
    if (n > TABLE_DEPTH_DEF) n = TABLE_DEPTH_DEF;
    lo = longint'(center) - longint'(half_reg);
    hi = longint'(center) + longint'(half_reg);
    span_lo = (lo > longint'(pos_tab[0])) ? lo : longint'(pos_tab[0]);
    span_hi = (hi < longint'(pos_tab[n-1])) ? hi : longint'(pos_tab[n-1]);
    r.average = '0;
    r.empty_window = 1'b1;
    if (span_hi <= span_lo || half_reg == '0) return r;
    acc = 0;
    for (int i = 0; i + 1 < n; i++) begin
      a = longint'(pos_tab[i]);
      b = longint'(pos_tab[i+1]);
      ca = (a > span_lo) ? a : span_lo;
      cb = (b < span_hi) ? b : span_hi;
      if (ca >= cb) continue;
      fa = interp(longint'(val_tab[i]), longint'(val_tab[i+1]), ca - a, b - a);
      fb = interp(longint'(val_tab[i]), longint'(val_tab[i+1]), cb - a, b - a);
      s = fa + fb;
      mag = (s < 0) ? longint'(-s) : longint'(s);
      // Products wrap at 64 bits, as in the datapath.
      half = (mag * longint'(cb - ca)) >> 1;
      v = (s < 0) ? -longint'(half) : longint'(half);
      if (v > 0 && acc > SUM_MAX - v) acc = SUM_MAX;
      else if (v < 0 && acc < SUM_MIN - v) acc = SUM_MIN;
      else acc = acc + v;
    end
    avg = acc / (2 * longint'(half_reg));
    if (avg > 64'sd2147483647) avg = 64'sd2147483647;
    if (avg < -64'sd2147483648) avg = -64'sd2147483648;
    r.average = avg[VAL_W-1:0];
    r.empty_window = 1'b0;
    return r;
  endfunction

  initial begin
    fail_count = 0;
    query_no = 0;
  end

  always @(posedge clk) begin
    average_t want;
    if (!rst_n) begin
      points_reg <= POINTS_RESET;
      half_reg <= HALF_RESET;
      expected_averages.delete();
    end else begin
      if (out_valid) begin
        if (expected_averages.size() == 0) begin
          report($sformatf("result beat with no query waiting: avg %0d empty %0b",
                           out_average, out_empty_window));
        end else begin
          want = expected_averages.pop_front();
          if (out_average !== want.average)
            report($sformatf("average %0d, want %0d", out_average, want.average));
          if (out_empty_window !== want.empty_window)
            report($sformatf("empty_window %0b, want %0b", out_empty_window,
                             want.empty_window));
        end
      end
      // A beat sees the registers as they stood before this edge.
      if (start && !busy) begin
        if (in_kind == KIND_LOAD) begin
          pos_tab[in_entry_index] = in_position;
          val_tab[in_entry_index] = in_sample_value;
        end else begin
          expected_averages.push_back(predict_average(in_position));
          query_no++;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_POINTS: begin
            points_reg <= cfg_wdata[PTS_W-1:0];
          end
          REG_HALF: begin
            half_reg <= cfg_wdata[HW_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: random and directed test of the windowed table average core
// Loads tables, sweeps the point count and window width through phases, and
// sends queries with random gaps; a checker module predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  import wta_pkg::*;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic                    in_kind;
  logic [IDX_W-1:0]        in_entry_index;
  logic [POS_W-1:0]        in_position;
  logic signed [VAL_W-1:0] in_sample_value;
  logic                    out_valid;
  logic signed [VAL_W-1:0] out_average;
  logic                    out_empty_window;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_wdata;
  int                      fail_count;
  int                      pending_averages;

  // Stimulus-side copy of the table positions, used only to aim the queries.
  logic [POS_W-1:0] aim_pos [TABLE_DEPTH_DEF];
  int               live_points;
  logic [HW_W-1:0]  live_half;
  bit               gaps_on;

  windowed_table_average_core i_dut (
    .clk, .rst_n, .start, .busy, .in_kind, .in_entry_index, .in_position,
    .in_sample_value, .out_valid, .out_average, .out_empty_window,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  wta_checker i_checker (
    .clk, .rst_n, .start, .busy, .in_kind, .in_entry_index, .in_position,
    .in_sample_value, .out_valid, .out_average, .out_empty_window,
    .cfg_we, .cfg_index, .cfg_wdata, .fail_count, .pending_averages
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Drives one beat and returns at the edge that accepts it. The start line
  // is left high, so back-to-back beats never lower and raise it in one step.
  task automatic send_beat(input logic kind, input logic [IDX_W-1:0] idx,
                           input logic [POS_W-1:0] pos,
                           input logic [VAL_W-1:0] value);
    if (gaps_on && $urandom_range(99) < 18) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= kind;
    in_entry_index <= idx;
    in_position <= pos;
    in_sample_value <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (kind == KIND_LOAD) aim_pos[idx] = pos;
  endtask

  // Holds the sender until every query has answered and the core is idle.
  // Loads give no result, so the wait runs on past idle to cover a trailing load.
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending_averages != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Fills entries 0..count-1. Mostly an ascending ramp; sometimes equal,
  // falling or scattered positions to reach the degenerate segment cases.
  task automatic load_table(input int count);
    longint unsigned p, step_max;
    int shape;
    shape = $urandom_range(99);
    step_max = 64'h1_0000_0000 / (count + 1);
    if ($urandom_range(1) == 1) step_max = $urandom_range(1, 32'h4_0000);
    p = $urandom_range(0, 32'h1_0000);
    for (int i = 0; i < count; i++) begin
      logic [31:0] value;
      value = ($urandom_range(3) == 0) ? $urandom : $signed($urandom_range(0, 32'h1FF_FFFF))
              - 32'sh100_0000;
      if (shape < 80) p = p + 1 + ({$urandom, $urandom} % step_max);
      else if (shape < 86) p = (i < count / 2) ? p : p + 1 + ($urandom % 32'h1_0000);
      else if (shape < 92) p = 64'hFFFF_0000 - longint'(i) * ($urandom_range(1, 32'h1_0000));
      else p = $urandom;
      if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
      send_beat(KIND_LOAD, i[IDX_W-1:0], p[31:0], value);
    end
  endtask

  // A query center, most of the time where the window meets the table span.
  task automatic send_query;
    longint lo, hi, c;
    int pick;
    pick = $urandom_range(99);
    lo = longint'(aim_pos[0]) - longint'(live_half);
    hi = longint'(aim_pos[live_points-1]) + longint'(live_half);
    if (hi <= lo) hi = lo + 1;
    if (pick < 75) c = lo + longint'({$urandom, $urandom} % longint'(hi - lo + 1));
    else if (pick < 80) c = 0;
    else if (pick < 85) c = 64'hFFFF_FFFF;
    else c = longint'($urandom);
    if (c < 0) c = 0;
    if (c > 64'hFFFF_FFFF) c = 64'hFFFF_FFFF;
    send_beat(KIND_QUERY, IDX_W'($urandom), c[31:0], $urandom);
  endtask

  initial begin
    int point_set [12] = '{2, 128, 5, 0, 255, 9, 1, 16, 3, 200, 7, 4};
    int query_set [12] = '{120, 6, 130, 120, 6, 110, 120, 90, 130, 6, 120, 130};
    logic [HW_W-1:0] half_set [12];
    rst_n = 1'b0;
    start = 1'b0;
    in_kind = KIND_LOAD;
    in_entry_index = '0;
    in_position = '0;
    in_sample_value = '0;
    cfg_we = 1'b0;
    cfg_index = REG_POINTS;
    cfg_wdata = '0;
    gaps_on = 1'b1;
    live_points = 2;
    live_half = HALF_RESET;
    half_set = '{24'd1, 24'hFF_FFFF, 24'h8000, 24'd0, 24'h1_0000, 24'h40_0000,
                 24'h2000, 24'h10, 24'h80_0000, 24'h4000, 24'hFF_FFFF, 24'd1};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: every entry gets written first so no query ever reads an
    // unwritten entry. The first pair carries the value extremes, then the
    // default window is aimed below zero, at the top end and into the span.
    send_beat(KIND_LOAD, 7'd0, 32'h0000_0000, 32'h8000_0000);
    send_beat(KIND_LOAD, 7'd1, 32'h0002_0000, 32'h7FFF_FFFF);
    for (int i = 2; i < TABLE_DEPTH_DEF; i++)
      send_beat(KIND_LOAD, i[IDX_W-1:0], 32'h0002_0000 + i * 32'h0200_0000 - 32'h0400_0000,
                $urandom);
    send_beat(KIND_LOAD, 7'd127, 32'hFFFF_FFFF, 32'h0100_0000);
    send_beat(KIND_QUERY, 7'd0, 32'h0000_0000, 32'd0);
    send_beat(KIND_QUERY, 7'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(KIND_QUERY, 7'd5, 32'h0001_0000, 32'h8000_0000);
    send_beat(KIND_QUERY, 7'd9, 32'h0002_0000, 32'h7FFF_FFFF);
    send_beat(KIND_QUERY, 7'd3, 32'h0000_8000, 32'd0);

    // Random phases. Each one first lets the core go idle, then sets the
    // registers (with an unused index thrown in), reloads the live entries
    // and mixes queries with single-entry rewrites.
    for (int ph = 0; ph < 12; ph++) begin
      drain();
      write_reg(REG_POINTS, CFG_DATA_W'(point_set[ph]));
      write_reg(REG_HALF, half_set[ph]);
      write_reg(CFG_IDX_W'(2 + $urandom_range(1)), CFG_DATA_W'($urandom));
      live_points = (point_set[ph] < 2) ? 2 :
                    (point_set[ph] > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : point_set[ph];
      live_half = half_set[ph];
      gaps_on = (ph != 2);
      load_table(live_points);
      for (int q = 0; q < query_set[ph]; q++) begin
        if ($urandom_range(99) < 8)
          send_beat(KIND_LOAD, IDX_W'($urandom_range(live_points - 1)), $urandom, $urandom);
        else
          send_query();
      end
    end

    drain();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending_averages == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run of every phase.
  initial begin
    #200_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
